/* hw/rtl/assert_macros.svh */
// Assertion macros for the allocator RTL.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LBA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LBA_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define LBA_ASSERT(label, clk, rst_n, prop)
`define LBA_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* hw/rtl/lba_pkg.sv */
// Types, codes and microcode program of the linked block allocator.
// No dependencies.
package lba_pkg;

    localparam int BLOCK_W             = 7;
    localparam int BLOCK_SPAN          = 2 ** BLOCK_W;
    localparam int LEN_W               = 7;
    localparam int SIZE_W              = 8;
    localparam int LBA_MAX_BLOCKS      = 128;
    localparam int LBA_MAX_FILE_BLOCKS = 64;
    localparam logic [SIZE_W-1:0] DISK_SIZE_RESET = 8'd128;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_IN_USE   = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [BLOCK_W-1:0] first_block;
        logic [LEN_W-1:0]   file_length;
    } t_req;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_number;
        t_status            status;
        logic               last;
    } t_res;

    typedef struct packed {
        logic [SIZE_W-1:0] disk_size;
    } t_cfg;

    // microcode steps, in program order
    typedef enum logic [3:0] {
        S_IDLE      = 4'd0,
        S_CHK_RANGE = 4'd1,
        S_CHK_USED  = 4'd2,
        S_CHK_LEN   = 4'd3,
        S_SCAN1     = 4'd4,
        S_CHK_FOUND = 4'd5,
        S_SCAN2     = 4'd6,
        S_DONE      = 4'd7,
        S_ERR_RANGE = 4'd8,
        S_ERR_USED  = 4'd9,
        S_ERR_SPACE = 4'd10
    } t_step;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_REQ,
        C_RANGE_BAD,
        C_USED,
        C_TOO_LONG,
        C_MORE,
        C_SHORT
    } t_cond;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_LOAD_START,
        IDX_INC_IF_MORE
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC_IF_FREE
    } t_cnt_op;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_OK_IF_FREE,
        EM_RANGE,
        EM_IN_USE,
        EM_NO_SPACE
    } t_emit;

    typedef struct packed {
        logic    take;
        t_idx_op idx_op;
        t_cnt_op cnt_op;
        t_emit   emit;
    } t_ctrl;

    typedef struct packed {
        t_cond cond;
        t_step target;
        t_ctrl ctrl;
    } t_uword;

    typedef struct packed {
        logic req_valid;
        logic range_bad;
        logic used;
        logic too_long;
        logic more;
        logic short_found;
        logic stall;
    } t_flags;

    // Control store. A true condition jumps to target, else the step advances; a stall holds the step.
    function automatic t_uword lba_rom(input t_step step);
        t_uword w;
        w.cond        = C_ALWAYS;
        w.target      = S_IDLE;
        w.ctrl.take   = 1'b0;
        w.ctrl.idx_op = IDX_HOLD;
        w.ctrl.cnt_op = CNT_HOLD;
        w.ctrl.emit   = EM_NONE;
        case (step)
            S_IDLE: begin
                w.ctrl.take = 1'b1;
                w.cond      = C_NO_REQ;
                w.target    = S_IDLE;
            end
            S_CHK_RANGE: begin
                w.cond   = C_RANGE_BAD;
                w.target = S_ERR_RANGE;
            end
            S_CHK_USED: begin
                w.cond   = C_USED;
                w.target = S_ERR_USED;
            end
            S_CHK_LEN: begin
                w.cond        = C_TOO_LONG;
                w.target      = S_ERR_SPACE;
                w.ctrl.cnt_op = CNT_CLEAR;
            end
            S_SCAN1: begin
                w.cond        = C_MORE;
                w.target      = S_SCAN1;
                w.ctrl.idx_op = IDX_INC_IF_MORE;
                w.ctrl.cnt_op = CNT_INC_IF_FREE;
            end
            S_CHK_FOUND: begin
                w.cond        = C_SHORT;
                w.target      = S_ERR_SPACE;
                w.ctrl.idx_op = IDX_LOAD_START;
                w.ctrl.cnt_op = CNT_CLEAR;
            end
            S_SCAN2: begin
                w.cond        = C_MORE;
                w.target      = S_SCAN2;
                w.ctrl.idx_op = IDX_INC_IF_MORE;
                w.ctrl.cnt_op = CNT_INC_IF_FREE;
                w.ctrl.emit   = EM_OK_IF_FREE;
            end
            S_ERR_RANGE: w.ctrl.emit = EM_RANGE;
            S_ERR_USED:  w.ctrl.emit = EM_IN_USE;
            S_ERR_SPACE: w.ctrl.emit = EM_NO_SPACE;
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/lba_stream_if.sv */
// Valid/ready channel carrying one payload word of type T.
// No dependencies; payload types come from lba_pkg at instantiation.
interface lba_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/lba_seq.sv */
// Microcode sequencer: step counter, control store fetch, conditional jumps.
// Depends on lba_pkg.
module lba_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lba_pkg::t_flags i_flags,
    output lba_pkg::t_ctrl  o_ctrl
);
    import lba_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_uword uw;
    logic   cond_hit;

    always_comb begin
        uw     = lba_rom(r_pc);
        o_ctrl = uw.ctrl;
    end

    always_comb begin
        case (uw.cond)
            C_ALWAYS:    cond_hit = 1'b1;
            C_NO_REQ:    cond_hit = !i_flags.req_valid;
            C_RANGE_BAD: cond_hit = i_flags.range_bad;
            C_USED:      cond_hit = i_flags.used;
            C_TOO_LONG:  cond_hit = i_flags.too_long;
            C_MORE:      cond_hit = i_flags.more;
            C_SHORT:     cond_hit = i_flags.short_found;
            default:     cond_hit = 1'b1;
        endcase
        if (i_flags.stall) begin
            n_pc = r_pc;
        end else if (cond_hit) begin
            n_pc = uw.target;
        end else begin
            n_pc = t_step'(r_pc + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* hw/rtl/lba_datapath.sv */
// Datapath: request registers, scan index and count, used-block bitmap memory,
// result register. Depends on lba_pkg, lba_stream_if, assert_macros.svh.
`include "assert_macros.svh"
module lba_datapath #(
    parameter int MAX_BLOCKS      = lba_pkg::LBA_MAX_BLOCKS,
    parameter int MAX_FILE_BLOCKS = lba_pkg::LBA_MAX_FILE_BLOCKS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lba_pkg::t_ctrl  i_ctrl,
    output lba_pkg::t_flags o_flags,
    lba_stream_if.sink      i_req,
    lba_stream_if.source    o_res,
    lba_stream_if.sink      i_cfg
);
    import lba_pkg::*;

    localparam int MapDepth = (MAX_BLOCKS < BLOCK_SPAN) ? MAX_BLOCKS : BLOCK_SPAN;
    localparam int AddrW    = (MapDepth > 1) ? $clog2(MapDepth) : 1;

    logic [SIZE_W-1:0]  r_disk_size;
    logic [BLOCK_W-1:0] r_start;
    logic [LEN_W-1:0]   r_length;
    logic [SIZE_W-1:0]  r_size;
    logic [BLOCK_W-1:0] r_idx;
    logic [BLOCK_W-1:0] n_idx;
    logic [LEN_W-1:0]   r_count;
    logic [LEN_W-1:0]   cnt_next;
    logic [SIZE_W-1:0]  idx_plus;

    logic               r_map_mem [MapDepth];
    logic [MapDepth-1:0] r_valid;
    logic               r_mem_q;
    logic               r_vld_q;
    logic               r_byp_q;
    logic [AddrW-1:0]   raddr;
    logic               in_map;

    logic               take;
    logic               used_now;
    logic               free_now;
    logic               cnt_inc;
    logic               more;
    logic               emit_need;
    logic               slot_free;
    logic               stall;
    logic               fire;
    logic               we;
    logic               r_res_valid;
    t_res               r_res;
    t_res               n_res;

    assign take      = i_ctrl.take && i_req.valid;
    assign used_now  = r_byp_q || (r_vld_q && r_mem_q);
    assign free_now  = !used_now;
    assign cnt_inc   = (i_ctrl.cnt_op == CNT_INC_IF_FREE) && free_now;
    assign cnt_next  = r_count + LEN_W'(cnt_inc);
    assign idx_plus  = SIZE_W'(r_idx) + 8'd1;
    assign more      = (idx_plus < r_size) && (cnt_next < r_length);
    assign slot_free = !r_res_valid || o_res.ready;

    always_comb begin
        case (i_ctrl.emit)
            EM_OK_IF_FREE: emit_need = free_now;
            EM_RANGE:      emit_need = 1'b1;
            EM_IN_USE:     emit_need = 1'b1;
            EM_NO_SPACE:   emit_need = 1'b1;
            default:       emit_need = 1'b0;
        endcase
    end

    assign stall = emit_need && !slot_free;
    assign fire  = emit_need && slot_free;
    assign we    = fire && (i_ctrl.emit == EM_OK_IF_FREE);

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = i_req.data.first_block;
        end else if (!stall) begin
            case (i_ctrl.idx_op)
                IDX_LOAD_START:  n_idx = r_start;
                IDX_INC_IF_MORE: if (more) n_idx = idx_plus[BLOCK_W-1:0];
                default:         n_idx = r_idx;
            endcase
        end
    end

    always_comb begin
        n_res.block_number = '0;
        n_res.last         = 1'b1;
        case (i_ctrl.emit)
            EM_OK_IF_FREE: begin
                n_res.block_number = r_idx;
                n_res.status       = ST_OK;
                n_res.last         = (cnt_next == r_length);
            end
            EM_RANGE:    n_res.status = ST_RANGE;
            EM_IN_USE:   n_res.status = ST_IN_USE;
            EM_NO_SPACE: n_res.status = ST_NO_SPACE;
            default:     n_res.status = ST_NO_SPACE;
        endcase
    end

    // the read port follows the next index, so used_now always matches r_idx
    assign in_map = SIZE_W'(n_idx) < SIZE_W'(MapDepth);
    assign raddr  = n_idx[AddrW-1:0];

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_map_mem[r_idx[AddrW-1:0]] <= 1'b1;
        end
        r_mem_q <= r_map_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_q <= 1'b0;
            r_byp_q <= 1'b0;
        end else begin
            if (we) begin
                r_valid[r_idx[AddrW-1:0]] <= 1'b1;
            end
            r_vld_q <= in_map && r_valid[raddr];
            r_byp_q <= we && (r_idx == n_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_size <= DISK_SIZE_RESET;
            r_idx       <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_disk_size <= i_cfg.data.disk_size;
            end
            r_idx <= n_idx;
            if (!stall) begin
                case (i_ctrl.cnt_op)
                    CNT_CLEAR:       r_count <= '0;
                    CNT_INC_IF_FREE: r_count <= cnt_next;
                    default:         r_count <= r_count;
                endcase
            end
            if (fire) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_start  <= i_req.data.first_block;
            r_length <= (i_req.data.file_length == '0) ? LEN_W'(1)
                                                       : i_req.data.file_length;
            r_size   <= (r_disk_size > SIZE_W'(MapDepth)) ? SIZE_W'(MapDepth)
                                                          : r_disk_size;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign i_req.ready = i_ctrl.take;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    assign o_flags.req_valid   = i_req.valid;
    assign o_flags.range_bad   = SIZE_W'(r_start) >= r_size;
    assign o_flags.used        = used_now;
    assign o_flags.too_long    = r_length > LEN_W'(MAX_FILE_BLOCKS);
    assign o_flags.more        = more;
    assign o_flags.short_found = r_count < r_length;
    assign o_flags.stall       = stall;

    `LBA_ASSERT(a_write_in_disk, i_clk, i_rst_n, we |-> (SIZE_W'(r_idx) < r_size))
    `LBA_ASSERT_NEVER(a_error_not_last, i_clk, i_rst_n, r_res_valid && (r_res.status != ST_OK) && !r_res.last)
    `LBA_ASSERT(a_count_below_len, i_clk, i_rst_n, (i_ctrl.cnt_op == CNT_INC_IF_FREE) |-> (r_count < r_length))
    `LBA_ASSERT(a_written_reads_used, i_clk, i_rst_n, (we && !take && (n_idx == r_idx)) |=> used_now)

endmodule

/* hw/rtl/linked_block_allocator.sv */
// Top level of the linked block allocator: sequencer plus datapath.
// Depends on lba_pkg, lba_stream_if, lba_seq, lba_datapath.
//
//  channel  dir  payload                               word moved when
//  i_req    in   first_block[6:0] file_length[6:0]     valid && ready
//  o_res    out  block_number[6:0] status[1:0] last    valid && ready
//  i_cfg    in   disk_size[7:0]                        valid && ready
//
// A request passes through an accept step, range, in-use and length checks, the
// counting scan, a found check, the allocating scan and a return step; the scans
// go through the single bitmap read port. Range, in-use and overlong errors are
// answered from their error steps; a shortfall, caught by the found check after
// the counting scan, is answered the same way.
// Reset clears the used flags at once; no clearing pass. i_req is ready only in
// the idle step; a full result register holds the sequencer on its emit step.
module linked_block_allocator #(
    parameter int MAX_BLOCKS      = lba_pkg::LBA_MAX_BLOCKS,
    parameter int MAX_FILE_BLOCKS = lba_pkg::LBA_MAX_FILE_BLOCKS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lba_stream_if.sink   i_req,
    lba_stream_if.source o_res,
    lba_stream_if.sink   i_cfg
);
    import lba_pkg::*;

    t_ctrl  ctrl;
    t_flags flags;

    lba_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    lba_datapath #(
        .MAX_BLOCKS      (MAX_BLOCKS),
        .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_flags (flags),
        .i_req   (i_req),
        .o_res   (o_res),
        .i_cfg   (i_cfg)
    );

endmodule

/* sim/tb_linked_block_allocator.sv */
`timescale 1ns / 1ps
// Testbench for linked_block_allocator: request driver, result monitor, bitmap predictor.
// Depends on lba_pkg, lba_stream_if and the allocator RTL.
module tb_linked_block_allocator;
    import lba_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam int unsigned ITEMS_PER_PHASE = 56;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned HOLD_PHASE      = 3;

    // directed requests, run with the reset disk size of 128
    localparam int unsigned NUM_DIRECTED = 15;
    int unsigned dir_start [NUM_DIRECTED] = '{0, 0, 1, 2, 3, 127, 64, 127, 100, 0,
                                              5, 2, 4, 9, 8};
    int unsigned dir_length[NUM_DIRECTED] = '{1, 5, 0, 127, 65, 64, 64, 1, 64, 127,
                                              60, 2, 3, 1, 3};

    // disk size per random phase, growing up to the 255 phase so fresh blocks keep opening up
    int unsigned phase_disk[NUM_PHASES] = '{0, 1, 16, 30, 44, 255, 70, 128};
    int unsigned send_idle_mode[4] = '{0, 48, 0, 27};
    int unsigned recv_stall_mode[4] = '{0, 0, 48, 27};

    logic i_clk = 1'b0;
    logic i_rst_n;

    lba_stream_if #(.T(t_req)) req_if ();
    lba_stream_if #(.T(t_res)) res_if ();
    lba_stream_if #(.T(t_cfg)) cfg_if ();

    linked_block_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted bitmap and disk size
    logic [LBA_MAX_BLOCKS-1:0] used_blocks;
    logic [SIZE_W-1:0]         disk_blocks;

    t_req outgoing_requests[$];
    t_res expected_grants[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;
    int unsigned requests_accepted;
    int unsigned status_seen[4];
    int unsigned cycle_count = 0;

    logic        hold_go;
    int unsigned hold_count;
    wire         hold_active = hold_go && (hold_count < LONG_HOLD);

    // Works out the answer to one request and updates the predicted bitmap.
    function automatic void allocate_blocks(input t_req req);
        int unsigned span;
        int unsigned first;
        int unsigned want;
        int unsigned found;
        int unsigned blk;
        t_res        grant;
        span  = (disk_blocks > LBA_MAX_BLOCKS) ? LBA_MAX_BLOCKS : disk_blocks;
        first = req.first_block;
        want  = (req.file_length == 0) ? 1 : req.file_length;
        grant = '0;
        grant.last = 1'b1;
        if (first >= span) begin
            grant.status = ST_RANGE;
        end else if (used_blocks[first]) begin
            grant.status = ST_IN_USE;
        end else if (want > LBA_MAX_FILE_BLOCKS) begin
            grant.status = ST_NO_SPACE;
        end else begin
            found = 1;
            for (blk = first + 1; blk < span && found < want; blk++) begin
                if (!used_blocks[blk])
                    found++;
            end
            if (found < want) begin
                grant.status = ST_NO_SPACE;
            end else begin
                // start block is free, so it is taken first
                found = 0;
                for (blk = first; blk < span && found < want; blk++) begin
                    if (!used_blocks[blk]) begin
                        used_blocks[blk]   = 1'b1;
                        found++;
                        grant.block_number = 7'(blk);
                        grant.status       = ST_OK;
                        grant.last         = (found == want);
                        expected_grants.push_back(grant);
                    end
                end
                return;
            end
        end
        expected_grants.push_back(grant);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                allocate_blocks(req_if.data);
                requests_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (outgoing_requests.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    req_if.data  <= outgoing_requests.pop_front();
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                status_seen[res_if.data.status]++;
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected word: block %0d status %0d last %0d", $time,
                             res_if.data.block_number, res_if.data.status, res_if.data.last);
                    mismatches++;
                end else begin
                    want = expected_grants.pop_front();
                    if (res_if.data.block_number !== want.block_number) begin
                        $display("%0t: block_number expected %0d actual %0d", $time,
                                 want.block_number, res_if.data.block_number);
                        mismatches++;
                    end
                    if (res_if.data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, res_if.data.status);
                        mismatches++;
                    end
                    if (res_if.data.last !== want.last) begin
                        $display("%0t: last expected %0d actual %0d", $time,
                                 want.last, res_if.data.last);
                        mismatches++;
                    end
                end
            end
            res_if.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here once armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_count <= 0;
        end else if (hold_active) begin
            hold_count <= hold_count + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("linked_block_allocator verification failed");
            $finish;
        end
    end

    task automatic wait_until_idle();
        do @(posedge i_clk);
        while (outgoing_requests.size() != 0 || req_if.valid || expected_grants.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned phase;
        int unsigned n;
        int unsigned span;
        int unsigned blk;
        int unsigned pick;
        int          free_list[$];
        t_req        req;

        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        res_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        hold_go        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        used_blocks    = '0;
        disk_blocks    = DISK_SIZE_RESET;
        mismatches     = 0;
        requests_accepted = 0;
        foreach (status_seen[k])
            status_seen[k] = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < NUM_DIRECTED; n++) begin
            req.first_block = 7'(dir_start[n]);
            req.file_length = 7'(dir_length[n]);
            outgoing_requests.push_back(req);
        end
        wait_until_idle();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct  = send_idle_mode[phase % 4];
            recv_stall_pct = recv_stall_mode[phase % 4];

            @(posedge i_clk);
            cfg_if.data.disk_size <= 8'(phase_disk[phase]);
            cfg_if.valid          <= 1'b1;
            do @(posedge i_clk);
            while (!cfg_if.ready);
            cfg_if.valid <= 1'b0;
            disk_blocks = 8'(phase_disk[phase]);

            if (phase == HOLD_PHASE)
                hold_go <= 1'b1;

            span = (phase_disk[phase] > LBA_MAX_BLOCKS) ? LBA_MAX_BLOCKS : phase_disk[phase];
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // keep the queue shallow so starts are chosen from a fresh bitmap
                while (outgoing_requests.size() >= 2)
                    @(posedge i_clk);
                free_list.delete();
                for (blk = 0; blk < span; blk++) begin
                    if (!used_blocks[blk])
                        free_list.push_back(blk);
                end
                if ($urandom_range(99) < 75 && free_list.size() != 0) begin
                    req.first_block = 7'(free_list[$urandom_range(free_list.size() - 1)]);
                    pick = $urandom_range(9);
                    if (pick < 7)
                        req.file_length = 7'($urandom_range(3, 1));
                    else if (pick < 9)
                        req.file_length = 7'($urandom_range(12, 4));
                    else
                        req.file_length = 7'($urandom_range(127));
                end else begin
                    req.first_block = 7'($urandom_range(127));
                    req.file_length = 7'($urandom_range(127));
                end
                outgoing_requests.push_back(req);
            end
            wait_until_idle();
        end

        $display("Ran %0d requests over the reset size and %0d programmed disk sizes,",
                 requests_accepted, NUM_PHASES);
        $display("with %0d blocks granted and %0d out-of-range, %0d in-use, %0d no-space rejects.",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_IN_USE],
                 status_seen[ST_NO_SPACE]);
        if (mismatches == 0) begin
            $display("linked_block_allocator verification clean");
        end else begin
            $display("linked_block_allocator verification failed");
        end
        $finish;
    end

endmodule
